FILE: rtl/core/iaie_pkg.sv
package iaie_pkg;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 11;
  localparam int AMT_W  = 11;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 11;
  localparam int CAP_W  = 12;
  localparam int ST_W   = 2;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ERASE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_GET    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SET    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] NX_SHIFT = 2'd0;
  localparam logic [1:0] NX_READ  = 2'd1;
  localparam logic [1:0] NX_DONE  = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic step;
    logic commit;
    logic grab;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] next_kind;
    logic       move_done;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: rtl/core/iaie_if.sv
interface iaie_in_if import iaie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         position;
  logic [AMT_W-1:0]         amount;
  logic signed [VAL_W-1:0]  element_value;
  logic                     last_of_run;

  modport source (output valid, func, position, amount, element_value, last_of_run,
                  input ready);
  modport sink   (input valid, func, position, amount, element_value, last_of_run,
                  output ready);
endinterface

interface iaie_out_if import iaie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  read_data;
  logic [CNT_W-1:0]         element_count;
  logic [CAP_W-1:0]         capacity_now;
  logic [ST_W-1:0]          status;

  modport source (output valid, read_data, element_count, capacity_now, status,
                  input ready);
  modport sink   (input valid, read_data, element_count, capacity_now, status,
                  output ready);
endinterface

FILE: rtl/core/iaie_ram.sv
module iaie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/iaie_ctrl.sv
module iaie_ctrl import iaie_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.next_kind)
          NX_SHIFT: state_nxt = S_SHIFT;
          NX_READ:  state_nxt = S_READ;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (sts.move_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_READ: begin
        cmd.grab  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/iaie_datapath.sv
module iaie_datapath import iaie_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic [POS_W-1:0]        in_position,
  input  logic [AMT_W-1:0]        in_amount,
  input  logic signed [VAL_W-1:0] in_element_value,
  input  logic                    in_last_of_run,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_read_data,
  output logic [CNT_W-1:0]        out_element_count,
  output logic [CAP_W-1:0]        out_capacity_now,
  output logic [ST_W-1:0]         out_status
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = CW + 1;
  localparam int XW   = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [FUNC_W-1:0]       func_r;
  logic [POS_W-1:0]        pos_r;
  logic [AMT_W-1:0]        amt_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    last_r;

  logic [CW-1:0]   count_r;
  logic [CAPW-1:0] cap_r;
  logic [CW-1:0]   cursor_r;
  logic            run_open_r;

  logic [AW-1:0] src_r;
  logic [AW-1:0] dst_r;
  logic [CW-1:0] left_r;
  logic          pend_r;
  logic          up_r;

  logic signed [VAL_W-1:0] res_data_r;
  logic [ST_W-1:0]         status_r;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_data_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic [CAP_W-1:0]        out_cap_r;
  logic [ST_W-1:0]         out_st_r;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  logic [XW-1:0] pos_x, amt_x, cnt_x, cur_x, depth_x, p_x;
  logic          ins_range, ins_full, ers_range, idx_range;
  logic [ST_W-1:0] st_code;
  logic [1:0]      kind;
  logic [CW-1:0]   count_inc;

  assign pos_x   = XW'(pos_r);
  assign amt_x   = XW'(amt_r);
  assign cnt_x   = XW'(count_r);
  assign cur_x   = XW'(cursor_r);
  assign depth_x = XW'(DEPTH);
  assign p_x     = run_open_r ? cur_x : pos_x;

  assign ins_range = !run_open_r && (pos_x > cnt_x);
  assign ins_full  = (cnt_x >= depth_x) || (p_x > cnt_x);
  assign ers_range = (pos_x + amt_x) > cnt_x;
  assign idx_range = (pos_x >= cnt_x) || (pos_x >= depth_x);

  assign count_inc = count_r + CW'(1);

  always_comb begin
    case (func_r)
      FN_INSERT: begin
        st_code = ins_range ? ST_RANGE : (ins_full ? ST_FULL : ST_OK);
        kind    = (ins_range || ins_full) ? NX_DONE : NX_SHIFT;
      end
      FN_ERASE: begin
        st_code = ers_range ? ST_RANGE : ST_OK;
        kind    = ers_range ? NX_DONE : NX_SHIFT;
      end
      FN_GET: begin
        st_code = idx_range ? ST_RANGE : ST_OK;
        kind    = idx_range ? NX_DONE : NX_READ;
      end
      default: begin
        st_code = idx_range ? ST_RANGE : ST_OK;
        kind    = NX_DONE;
      end
    endcase
  end

  assign sts.next_kind = kind;
  assign sts.move_done = (left_r == '0) && !pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // element store port muxing
  assign raddr = cmd.exec ? AW'(pos_r) : src_r;

  always_comb begin
    we    = 1'b0;
    waddr = dst_r;
    wdata = rdata;
    if (cmd.step && pend_r) begin
      we = 1'b1;
    end
    if (cmd.commit && (func_r == FN_INSERT)) begin
      we    = 1'b1;
      wdata = val_r;
    end
    if (cmd.exec && (func_r == FN_SET) && !idx_range) begin
      we    = 1'b1;
      waddr = AW'(pos_r);
      wdata = val_r;
    end
  end

  iaie_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAPW'(1);
      cursor_r    <= '0;
      run_open_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pend_r <= 1'b0;
        if (func_r != FN_INSERT) begin
          run_open_r <= 1'b0;
        end else if (!ins_range && ins_full && last_r) begin
          run_open_r <= 1'b0;
        end
      end
      if (cmd.step) begin
        pend_r <= (left_r != '0);
      end
      if (cmd.commit) begin
        if (func_r == FN_INSERT) begin
          count_r <= count_inc;
          if (CAPW'(count_inc) >= cap_r) begin
            cap_r <= cap_r << 1;
          end
          run_open_r <= !last_r;
          cursor_r   <= CW'(dst_r) + CW'(1);
        end else begin
          count_r <= count_r - CW'(amt_r);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      pos_r  <= in_position;
      amt_r  <= in_amount;
      val_r  <= in_element_value;
      last_r <= in_last_of_run;
    end
    if (cmd.exec) begin
      status_r   <= st_code;
      res_data_r <= '0;
      if (func_r == FN_INSERT) begin
        src_r  <= AW'(count_r) - AW'(1);
        dst_r  <= AW'(count_r);
        left_r <= CW'(cnt_x - p_x);
        up_r   <= 1'b0;
      end else begin
        src_r  <= AW'(pos_x + amt_x);
        dst_r  <= AW'(pos_r);
        left_r <= (amt_r == '0) ? '0 : CW'(cnt_x - pos_x - amt_x);
        up_r   <= 1'b1;
      end
    end
    if (cmd.step) begin
      if (left_r != '0) begin
        src_r  <= up_r ? (src_r + AW'(1)) : (src_r - AW'(1));
        left_r <= left_r - CW'(1);
      end
      if (pend_r) begin
        dst_r <= up_r ? (dst_r + AW'(1)) : (dst_r - AW'(1));
      end
    end
    if (cmd.grab) begin
      res_data_r <= rdata;
    end
    if (cmd.load_out) begin
      out_data_r <= res_data_r;
      out_cnt_r  <= CNT_W'(count_r);
      out_cap_r  <= CAP_W'(cap_r);
      out_st_r   <= status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_data_r;
  assign out_element_count = out_cnt_r;
  assign out_capacity_now  = out_cap_r;
  assign out_status        = out_st_r;

endmodule

FILE: rtl/core/indexed_array_insert_erase_unit.sv
// Channel   Dir  Word                                              Accepted when
// in_ch     in   func, position, amount, element_value, last_of_run  valid && ready
// out_ch    out  read_data, element_count, capacity_now, status      valid && ready
//
// Each word goes idle, exec, shift or read as needed, then done; the next
// word is taken only in idle. Insert and erase move n = elements shifted,
// one per cycle through the store's single read and write port.
// Synchronous active-low reset zeroes count and run state, sets capacity
// to one; store contents are undefined until written, no clearing pass.
// A held result parks the next one in the controller; a new word is taken
// as soon as the controller is idle, even with a result still waiting.
module indexed_array_insert_erase_unit import iaie_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input logic       clk,
  input logic       rst_n,
  iaie_in_if.sink   in_ch,
  iaie_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  iaie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iaie_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_ch.func),
    .in_position       (in_ch.position),
    .in_amount         (in_ch.amount),
    .in_element_value  (in_ch.element_value),
    .in_last_of_run    (in_ch.last_of_run),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_read_data     (out_ch.read_data),
    .out_element_count (out_ch.element_count),
    .out_capacity_now  (out_ch.capacity_now),
    .out_status        (out_ch.status)
  );

endmodule

FILE: rtl/core/iaie_checker.sv
module iaie_checker import iaie_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] read_data,
  input logic [CNT_W-1:0]        element_count,
  input logic [CAP_W-1:0]        capacity_now,
  input logic [ST_W-1:0]         status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({read_data, element_count, capacity_now, status}))
    else $error("result word changed while stalled");

  a_cap_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(capacity_now))
    else $error("capacity not a power of two");

  a_cap_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, element_count} < capacity_now)
    else $error("capacity not above element count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (read_data == '0))
    else $error("read data nonzero on error");

endmodule

bind indexed_array_insert_erase_unit iaie_checker u_iaie_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .read_data     (out_ch.read_data),
  .element_count (out_ch.element_count),
  .capacity_now  (out_ch.capacity_now),
  .status        (out_ch.status)
);

FILE: tb/sv/indexed_array_insert_erase_unit_tb.sv
`timescale 1ns / 100ps

module indexed_array_insert_erase_unit_tb import iaie_pkg::*;;

  localparam int DEPTH      = 1024;
  localparam int RAND_WORDS = 542;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        position;
    logic [AMT_W-1:0]        amount;
    logic signed [VAL_W-1:0] element_value;
    logic                    last_of_run;
  } op_word_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_data;
    logic [CNT_W-1:0]        element_count;
    logic [CAP_W-1:0]        capacity_now;
    logic [ST_W-1:0]         status;
  } reply_t;

  class elem_array_mirror;
    logic signed [VAL_W-1:0] elems [DEPTH];
    int     elem_count;
    int     cap;
    int     run_pos;
    bit     run_live;
    int     peak;
    reply_t pending_replies[$];
    int     mismatches;
    int     n_checked;
    int     n_ok;
    int     n_range;
    int     n_full;

    function new();
      elem_count = 0;
      cap        = 1;
      run_pos    = 0;
      run_live   = 0;
      peak       = 0;
      mismatches = 0;
      n_checked  = 0;
      n_ok       = 0;
      n_range    = 0;
      n_full     = 0;
    endfunction

    function void take_word(op_word_t w);
      reply_t r;
      int     p;
      int     a;
      int     i;
      r.read_data = '0;
      r.status    = ST_OK;
      p = int'(w.position);
      a = int'(w.amount);
      if (w.func == FN_INSERT) begin
        if (run_live) p = run_pos;
        if (!run_live && p > elem_count) begin
          r.status = ST_RANGE;
        end else if (elem_count >= DEPTH || p > elem_count) begin
          r.status = ST_FULL;
          if (w.last_of_run) run_live = 0;
        end else begin
          for (i = elem_count; i > p; i--) elems[i] = elems[i-1];
          elems[p] = w.element_value;
          elem_count++;
          while (elem_count >= cap) cap *= 2;
          if (w.last_of_run) begin
            run_live = 0;
          end else begin
            run_live = 1;
            run_pos  = p + 1;
          end
        end
      end else begin
        run_live = 0;
        if (w.func == FN_ERASE) begin
          if (p + a > elem_count) begin
            r.status = ST_RANGE;
          end else begin
            for (i = p; i + a < elem_count; i++) elems[i] = elems[i+a];
            elem_count -= a;
          end
        end else if (p >= elem_count || p >= DEPTH) begin
          r.status = ST_RANGE;
        end else if (w.func == FN_GET) begin
          r.read_data = elems[p];
        end else begin
          elems[p] = w.element_value;
        end
      end
      if (elem_count > peak) peak = elem_count;
      r.element_count = elem_count[CNT_W-1:0];
      r.capacity_now  = cap[CAP_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("result word with nothing pending: count %0d status %0d",
               got.element_count, got.status);
        mismatches++;
        return;
      end
      exp = pending_replies.pop_front();
      n_checked++;
      case (exp.status)
        ST_OK:    n_ok++;
        ST_RANGE: n_range++;
        default:  n_full++;
      endcase
      if (got.read_data !== exp.read_data) begin
        $error("read_data: expected %0d, got %0d", exp.read_data, got.read_data);
        mismatches++;
      end
      if (got.element_count !== exp.element_count) begin
        $error("element_count: expected %0d, got %0d",
               exp.element_count, got.element_count);
        mismatches++;
      end
      if (got.capacity_now !== exp.capacity_now) begin
        $error("capacity_now: expected %0d, got %0d",
               exp.capacity_now, got.capacity_now);
        mismatches++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  iaie_in_if  in_ch ();
  iaie_out_if out_ch ();

  indexed_array_insert_erase_unit #(.DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  elem_array_mirror sb = new();

  int words_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input logic [FUNC_W-1:0] f, input int pos, input int amt,
                       input logic [VAL_W-1:0] v, input bit last);
    op_word_t w;
    int       gap;
    w.func          = f;
    w.position      = pos[POS_W-1:0];
    w.amount        = amt[AMT_W-1:0];
    w.element_value = v;
    w.last_of_run   = last;
    in_ch.valid         <= 1'b1;
    in_ch.func          <= w.func;
    in_ch.position      <= w.position;
    in_ch.amount        <= w.amount;
    in_ch.element_value <= w.element_value;
    in_ch.last_of_run   <= w.last_of_run;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_word(w);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 30);
      gap = 0;
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_data     = out_ch.read_data;
      got.element_count = out_ch.element_count;
      got.capacity_now  = out_ch.capacity_now;
      got.status        = out_ch.status;
      sb.check_reply(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side: random back-pressure, plus two long holds to fill the block
  initial begin : result_sink
    int gap;
    int hold_at;
    hold_at = 150;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (hold_at <= 450 && sb.n_checked >= hold_at) begin
        gap = HOLD_LEN;
        hold_at += 300;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : word_source
    int                rand_words;
    int                sel;
    int                len;
    int                k;
    int                p;
    int                a;
    bit                last;
    bit                broken;
    logic [FUNC_W-1:0] f;

    rand_words = 0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FN_INSERT;
    in_ch.position      <= '0;
    in_ch.amount        <= '0;
    in_ch.element_value <= '0;
    in_ch.last_of_run   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, bounds, run behavior, extremes
    issue(FN_GET,    0,    0,    32'h0,        1'b0);
    issue(FN_ERASE,  0,    0,    32'h0,        1'b0);
    issue(FN_ERASE,  1024, 1024, 32'h0,        1'b1);
    issue(FN_INSERT, 1,    0,    32'h1,        1'b1);
    issue(FN_INSERT, 1024, 0,    32'h2,        1'b0);
    issue(FN_INSERT, 0,    0,    32'h7FFFFFFF, 1'b1);
    issue(FN_INSERT, 0,    0,    32'h80000000, 1'b0);
    issue(FN_INSERT, 1024, 2047, 32'hFFFFFFFF, 1'b0);
    issue(FN_INSERT, 0,    0,    32'h0,        1'b1);
    issue(FN_INSERT, 2,    0,    32'h5,        1'b0);
    issue(FN_GET,    0,    1024, 32'hFFFFFFFF, 1'b1);
    issue(FN_INSERT, 5,    0,    32'h6,        1'b1);
    issue(FN_SET,    3,    0,    32'h55555555, 1'b0);
    issue(FN_SET,    6,    0,    32'hAAAAAAAA, 1'b0);
    issue(FN_GET,    3,    0,    32'h0,        1'b0);
    issue(FN_GET,    2,    0,    32'h0,        1'b0);
    issue(FN_GET,    1024, 0,    32'h0,        1'b0);
    issue(FN_ERASE,  1,    2,    32'h0,        1'b0);
    issue(FN_ERASE,  3,    2,    32'h0,        1'b0);
    issue(FN_GET,    1,    0,    32'h0,        1'b0);
    issue(FN_ERASE,  0,    4,    32'h0,        1'b0);
    issue(FN_INSERT, 0,    0,    32'h12345678, 1'b0);
    issue(FN_SET,    0,    0,    32'h87654321, 1'b0);
    issue(FN_GET,    0,    0,    32'h0,        1'b0);
    issue(FN_ERASE,  0,    1,    32'h0,        1'b0);

    while (rand_words < RAND_WORDS) begin
      sel = $urandom_range(0, 99);
      if (sb.elem_count > 64) sel = 45;
      if (sel < 40) begin
        len    = $urandom_range(1, 6);
        broken = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          if (k == 0 && !sb.run_live) p = $urandom_range(0, sb.elem_count);
          else p = $urandom_range(0, 1024);
          last = (k == len - 1) && !broken;
          issue(FN_INSERT, p, $urandom_range(0, 1024), $urandom, last);
          rand_words++;
        end
      end else if (sel < 55) begin
        if (sb.elem_count > 64) begin
          p = $urandom_range(0, 8);
          a = sb.elem_count - p - $urandom_range(0, 8);
        end else if ($urandom_range(0, 6) == 0) begin
          p = $urandom_range(0, 1024);
          a = $urandom_range(0, 1024);
        end else begin
          p = $urandom_range(0, sb.elem_count);
          a = $urandom_range(0, sb.elem_count - p);
        end
        issue(FN_ERASE, p, a, $urandom, 1'($urandom_range(0, 1)));
        rand_words++;
      end else if (sel < 90) begin
        f = (sel < 75) ? FN_GET : FN_SET;
        if (sb.elem_count > 0 && $urandom_range(0, 7) != 0)
          p = $urandom_range(0, sb.elem_count - 1);
        else
          p = $urandom_range(0, 1024);
        issue(f, p, $urandom_range(0, 1024), $urandom, 1'($urandom_range(0, 1)));
        rand_words++;
      end else begin
        f = FUNC_W'($urandom_range(0, 3));
        issue(f, $urandom_range(0, 1024), $urandom_range(0, 1024), $urandom,
              1'($urandom_range(0, 1)));
        rand_words++;
      end
    end

    // tail: runs, bounds and top-of-range positions on the loaded store
    issue(FN_GET, 0, 0, 32'h0, 1'b0);
    issue(FN_INSERT, 0,    0,    32'h0BADF00D, 1'b0);
    issue(FN_INSERT, 1024, 1024, $urandom,     1'b0);
    issue(FN_INSERT, 0,    0,    $urandom,     1'b1);
    issue(FN_INSERT, 1024, 0,    $urandom,     1'b1);
    issue(FN_GET,    1023, 0,    32'h0,        1'b0);
    issue(FN_SET,    1023, 0,    $urandom,     1'b0);
    issue(FN_GET,    1023, 0,    32'h0,        1'b0);
    issue(FN_GET,    0,    0,    32'h0,        1'b0);
    issue(FN_GET,    1024, 0,    32'h0,        1'b0);
    issue(FN_ERASE,  0,    1024, 32'h0,        1'b0);
    issue(FN_INSERT, 0,    0,    $urandom,     1'b1);
    issue(FN_GET,    0,    0,    32'h0,        1'b0);

    in_ch.valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("summary: %0d words sent, %0d results checked (ok %0d, range %0d, full %0d)",
             words_sent, sb.n_checked, sb.n_ok, sb.n_range, sb.n_full);
    $display("summary: peak element count %0d, final capacity %0d, %0d mismatches",
             sb.peak, sb.cap, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/iaie_pkg.sv
rtl/core/iaie_if.sv
rtl/core/iaie_ram.sv
rtl/core/iaie_ctrl.sv
rtl/core/iaie_datapath.sv
rtl/core/indexed_array_insert_erase_unit.sv
rtl/core/iaie_checker.sv
tb/sv/indexed_array_insert_erase_unit_tb.sv
